// ----- hw/rtl/sha256_pkg.sv -----
// sha256_pkg: payload structs, round constants and a rotate helper for the hasher
// no dependencies
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_byte;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- hw/rtl/sha256_stream_hasher_unit.sv -----
// sha256_stream_hasher_unit: streaming sha-256 / sha256d hasher top level
// depends on sha256_pkg
// rate: one byte word a cycle while the buffer fills; a full block stalls input through load,
// rounds and update; a last word adds padding one byte at a time up to 56, the length bytes and
// another compression, a second block (pad to 64, compress, pad to 56, compress) when fill > 55,
// and a second hash in double mode; the digest then leaves as 8 words, one a cycle unless stalled
// reset: rst_n async low, chaining state to initial values, counters cleared, no clearing
// pass (buffer and schedule memories are written before read)
module sha256_stream_hasher_unit
    import sha256_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  sha_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output sha_out_t out_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_LOAD  = 7'b0000100,
        ST_ROUND = 7'b0001000,
        ST_UPD   = 7'b0010000,
        ST_DBL   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    // block buffer memory: 16 words of 32 bits, byte-lane writes
    logic [31:0] buf_mem [16];
    // schedule memory: 16 words, rolling window
    logic [31:0] sch_mem [16];

    state_t      state_reg, state_next;
    logic        dbl_reg;
    logic [31:0] hv_reg [8];
    logic [31:0] rv_reg [8];
    logic [6:0]  fill_reg;        // bytes in buffer, 0..63; 64 marks the length phase
    logic [60:0] total_reg;
    logic [6:0]  rnd_reg;         // load/round counter
    logic        final_reg;       // this block ends the message
    logic        second_reg;      // doing second pass of sha256d
    logic        pad80_reg;       // 0x80 already placed, rest of padding is zeros
    logic        padpend_reg;     // last byte filled a block, padding starts fresh
    logic [2:0]  oidx_reg;
    logic [31:0] buf_rd_reg;
    logic [31:0] w15_reg, w2_reg, w16_reg, w7_reg;

    // byte write port into the buffer
    logic        bw_en;
    logic [5:0]  bw_addr;
    logic [7:0]  bw_byte;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);

    wire take = in_valid && !in_stall;

    logic [6:0] fill_inc;
    assign fill_inc = fill_reg + {6'd0, in_data.has_byte};

    // schedule word: first 16 from buffer, then recurrence
    logic [31:0] s0, s1, w_cur;
    assign s0 = rotr(w15_reg, 7) ^ rotr(w15_reg, 18) ^ (w15_reg >> 3);
    assign s1 = rotr(w2_reg, 17) ^ rotr(w2_reg, 19) ^ (w2_reg >> 10);

    logic [5:0] ri;
    assign ri = rnd_reg[5:0];

    always_comb
    begin
        if (ri < 6'd16)
            w_cur = w16_reg;
        else
            w_cur = w16_reg + s0 + w7_reg + s1;
    end

    // round function
    logic [31:0] t1, t2;
    assign t1 = rv_reg[7] + (rotr(rv_reg[4], 6) ^ rotr(rv_reg[4], 11) ^ rotr(rv_reg[4], 25))
              + ((rv_reg[4] & rv_reg[5]) ^ (~rv_reg[4] & rv_reg[6])) + ROUND_K[ri] + w_cur;
    assign t2 = (rotr(rv_reg[0], 2) ^ rotr(rv_reg[0], 13) ^ rotr(rv_reg[0], 22))
              + ((rv_reg[0] & rv_reg[1]) ^ (rv_reg[0] & rv_reg[2]) ^ (rv_reg[1] & rv_reg[2]));

    always_ff @(posedge clk)
    begin
        if (bw_en)
        begin
            case (bw_addr[1:0])
                2'd0:    buf_mem[bw_addr[5:2]][31:24] <= bw_byte;
                2'd1:    buf_mem[bw_addr[5:2]][23:16] <= bw_byte;
                2'd2:    buf_mem[bw_addr[5:2]][15:8]  <= bw_byte;
                default: buf_mem[bw_addr[5:2]][7:0]   <= bw_byte;
            endcase
        end
        buf_rd_reg <= buf_mem[rnd_reg[3:0]];
    end

    // schedule memory: load copies buffer words, rounds write back new w
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && rnd_reg != 7'd0)
            sch_mem[4'(rnd_reg - 7'd1)] <= buf_rd_reg;
        else if (state_reg == ST_ROUND && ri >= 6'd16)
            sch_mem[ri[3:0]] <= w_cur;
    end

    // operands for the next round, read one round ahead; during load word 0 for round 0
    logic [5:0] nr;
    assign nr = (state_reg == ST_ROUND) ? ri + 6'd1 : 6'd0;
    always_ff @(posedge clk)
    begin
        // w[nr-2] is w[ri-1], written at the previous edge, so it is already in memory
        w15_reg <= sch_mem[4'(nr - 6'd15)];
        w16_reg <= sch_mem[nr[3:0]];
        w7_reg  <= sch_mem[4'(nr - 6'd7)];
        w2_reg  <= sch_mem[4'(nr - 6'd2)];
    end

    // digest byte stream for double mode, and padding bytes
    logic [31:0] hsel;
    assign hsel = hv_reg[rnd_reg[4:2]];

    logic [63:0] bits;
    assign bits = {total_reg, 3'b000};

    always_comb
    begin
        bw_en   = 1'b0;
        bw_addr = fill_reg[5:0];
        bw_byte = in_data.data_byte;
        case (state_reg)
            ST_IDLE:
            begin
                bw_en = take && in_data.has_byte;
            end
            ST_PAD:
            begin
                bw_en = 1'b1;
                if (fill_reg[6])
                begin
                    // length bytes 56..63, most significant first
                    bw_addr = LEN_OFFSET + 6'(rnd_reg[2:0]);
                    bw_byte = bits[{~rnd_reg[2:0], 3'b000} +: 8];
                end
                else if (pad80_reg)
                    bw_byte = 8'h00;
                else
                    bw_byte = PAD_BYTE;
            end
            ST_DBL:
            begin
                bw_en   = 1'b1;
                bw_addr = rnd_reg[5:0];
                case (rnd_reg[1:0])
                    2'd0:    bw_byte = hsel[31:24];
                    2'd1:    bw_byte = hsel[23:16];
                    2'd2:    bw_byte = hsel[15:8];
                    default: bw_byte = hsel[7:0];
                endcase
            end
            default: bw_en = 1'b0;
        endcase
    end

    // state and counter registers; in ST_PAD, fill_reg[6] set means the length phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            dbl_reg     <= 1'b0;
            fill_reg    <= '0;
            total_reg   <= '0;
            rnd_reg     <= '0;
            final_reg   <= 1'b0;
            second_reg  <= 1'b0;
            pad80_reg   <= 1'b0;
            padpend_reg <= 1'b0;
            oidx_reg    <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hv_reg[i] <= INIT_HASH[i];
                rv_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                dbl_reg <= cfg_data;
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        rnd_reg   <= '0;
                        pad80_reg <= 1'b0;
                        if (in_data.has_byte)
                            total_reg <= total_reg + 61'd1;
                        if (fill_inc == 7'd64)
                        begin
                            // full block, padding (if last) goes in the next one
                            fill_reg    <= '0;
                            padpend_reg <= in_data.last_byte;
                        end
                        else
                            fill_reg <= fill_inc;
                    end
                end
                ST_PAD:
                begin
                    if (!fill_reg[6])
                    begin
                        pad80_reg   <= 1'b1;
                        padpend_reg <= 1'b0;
                        if (fill_reg[5:0] == 6'd63)
                        begin
                            // no room for the length, compress and continue in a fresh block
                            fill_reg <= '0;
                            rnd_reg  <= '0;
                        end
                        else if (fill_reg[5:0] == LEN_OFFSET - 6'd1)
                        begin
                            fill_reg <= 7'd64;
                            rnd_reg  <= '0;
                        end
                        else
                            fill_reg <= fill_reg + 7'd1;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg + 7'd1;
                        if (rnd_reg[2:0] == 3'd7)
                        begin
                            rnd_reg   <= '0;
                            fill_reg  <= '0;
                            final_reg <= 1'b1;
                        end
                    end
                end
                ST_LOAD:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd16)
                    begin
                        rnd_reg <= '0;
                        for (int i = 0; i < 8; i++)
                            rv_reg[i] <= hv_reg[i];
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    rv_reg[7] <= rv_reg[6];
                    rv_reg[6] <= rv_reg[5];
                    rv_reg[5] <= rv_reg[4];
                    rv_reg[4] <= rv_reg[3] + t1;
                    rv_reg[3] <= rv_reg[2];
                    rv_reg[2] <= rv_reg[1];
                    rv_reg[1] <= rv_reg[0];
                    rv_reg[0] <= t1 + t2;
                end
                ST_UPD:
                begin
                    for (int i = 0; i < 8; i++)
                        hv_reg[i] <= hv_reg[i] + rv_reg[i];
                    rnd_reg  <= '0;
                    fill_reg <= '0;
                end
                ST_DBL:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd31)
                    begin
                        for (int i = 0; i < 8; i++)
                            hv_reg[i] <= INIT_HASH[i];
                        fill_reg    <= 7'd32;
                        total_reg   <= 61'd32;
                        rnd_reg     <= '0;
                        second_reg  <= 1'b1;
                        final_reg   <= 1'b0;
                        pad80_reg   <= 1'b0;
                        padpend_reg <= 1'b0;
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                hv_reg[i] <= INIT_HASH[i];
                            fill_reg    <= '0;
                            total_reg   <= '0;
                            second_reg  <= 1'b0;
                            pad80_reg   <= 1'b0;
                            padpend_reg <= 1'b0;
                            final_reg   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && in_data.has_byte && fill_reg == 7'd63)
                    state_next = ST_LOAD;
                else if (take && in_data.last_byte)
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                if (!fill_reg[6] && fill_reg[5:0] == 6'd63)
                    state_next = ST_LOAD;
                else if (fill_reg[6] && rnd_reg[2:0] == 3'd7)
                    state_next = ST_LOAD;
            end
            ST_LOAD:  if (rnd_reg == 7'd16) state_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == 7'd63) state_next = ST_UPD;
            ST_UPD:
            begin
                if (final_reg)
                begin
                    if (dbl_reg && !second_reg)
                        state_next = ST_DBL;
                    else
                        state_next = ST_OUT;
                end
                else if (pad80_reg || padpend_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_DBL:   if (rnd_reg == 7'd31) state_next = ST_PAD;
            ST_OUT:   if (!out_stall && oidx_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign out_valid            = (state_reg == ST_OUT);
    assign out_data.digest_word = hv_reg[oidx_reg];
    assign out_data.word_index  = oidx_reg;
    assign out_data.last_word   = (oidx_reg == 3'd7);

`ifndef SYNTH
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall) else $error("input taken while busy");
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> fill_reg < 7'd64) else $error("fill out of range");
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && oidx_reg != 3'd7 |=> out_valid)
        else $error("digest words interrupted");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
`endif

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for sha256_stream_hasher_unit (sha-256 and sha256d)
// depends on sha256_pkg and the hasher rtl; byte words in, digest words checked against
// a behavioral sha-256 predictor kept inside this file
`timescale 1ns / 1ps

module tb_top;
    import sha256_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 400;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    sha_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    sha_out_t out_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_data;

    sha256_stream_hasher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state, mirrors the hasher between words
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int          block_fill;
    logic [60:0] msg_bytes;
    logic        double_mode;

    sha_in_t  byte_queue [$];     // words waiting for the driver
    sha_out_t digest_queue [$];   // digest words still to come from the hasher
    int       error_count;
    int       idle_cycles;
    int       hold_cycles;        // long receiver hold-off, counted in the stall process
    int       in_gap;
    bit       hold_request;
    bit       run_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of msg_block into hash_state
    task automatic compress_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + sched[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
            hash_state[i] = INIT_HASH[i];
        block_fill = 0;
        msg_bytes  = '0;
    endtask

    task automatic absorb_byte(logic [7:0] b);
        msg_block[block_fill] = b;
        block_fill++;
        msg_bytes++;
        if (block_fill == 64)
        begin
            compress_block();
            block_fill = 0;
        end
    endtask

    // padding, length field and final compression
    task automatic pad_and_close();
        logic [63:0] bit_len;
        bit_len = {msg_bytes, 3'b000};
        msg_block[block_fill] = PAD_BYTE;
        block_fill++;
        if (block_fill > 56)
        begin
            while (block_fill < 64)
                msg_block[block_fill++] = 8'h00;
            compress_block();
            block_fill = 0;
        end
        while (block_fill < 56)
            msg_block[block_fill++] = 8'h00;
        for (int i = 0; i < 8; i++)
            msg_block[56+i] = bit_len[63-8*i -: 8];
        compress_block();
        block_fill = 0;
    endtask

    // work out the digest words that one accepted byte word causes
    task automatic predict_digest(sha_in_t w);
        logic [31:0] first [8];
        sha_out_t    r;
        if (w.has_byte)
            absorb_byte(w.data_byte);
        if (w.last_byte)
        begin
            pad_and_close();
            if (double_mode)
            begin
                first = hash_state;
                restart_message();
                for (int i = 0; i < 8; i++)
                    for (int k = 3; k >= 0; k--)
                        absorb_byte(first[i][8*k +: 8]);
                pad_and_close();
            end
            for (int i = 0; i < 8; i++)
            begin
                r.digest_word = hash_state[i];
                r.word_index  = i[2:0];
                r.last_word   = (i == 7);
                digest_queue.push_back(r);
            end
            restart_message();
        end
    endtask

    // ---------------------------------------------------------------
    // driver: byte words from byte_queue, random gaps between them
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            // a word is taken when valid is high and stall is low
            if (in_valid && !in_stall)
                predict_digest(in_data);
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (byte_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= byte_queue.pop_front();
                    // most gaps short, some long, many stretches with none
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3:  in_gap <= $urandom_range(1, 3);
                        4:           in_gap <= $urandom_range(10, 60);
                        default:     in_gap <= 0;
                    endcase
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver stall and monitor
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_cycles <= 0;
        end
        else
        begin
            if (hold_request && hold_cycles == 0)
            begin
                // long hold-off while the sender keeps offering bytes
                hold_cycles <= 1500;
                out_stall   <= 1'b1;
            end
            else if (hold_cycles > 1)
            begin
                hold_cycles <= hold_cycles - 1;
                out_stall   <= 1'b1;
            end
            else
            begin
                hold_cycles <= (hold_cycles == 1) ? -1 : hold_cycles;
                case ($urandom_range(0, 19))
                    0, 1, 2:  out_stall <= 1'b1;
                    3:        out_stall <= ($urandom_range(0, 3) != 0);
                    default:  out_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_queue.size() == 0)
            begin
                $display("%0t: unexpected digest word, got %h idx %0d last %0b", $time,
                         out_data.digest_word, out_data.word_index, out_data.last_word);
                error_count++;
            end
            else
            begin
                sha_out_t want;
                want = digest_queue.pop_front();
                if (out_data.digest_word !== want.digest_word)
                begin
                    $display("%0t: digest_word expected %h actual %h", $time,
                             want.digest_word, out_data.digest_word);
                    error_count++;
                end
                if (out_data.word_index !== want.word_index)
                begin
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             want.word_index, out_data.word_index);
                    error_count++;
                end
                if (out_data.last_word !== want.last_word)
                begin
                    $display("%0t: last_word expected %0b actual %0b", $time,
                             want.last_word, out_data.last_word);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles with no word accepted on input, output or config
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready) || run_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** sha256_stream_hasher_unit: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    function automatic sha_in_t make_word(logic [7:0] b, logic has, logic last);
        sha_in_t w;
        w.data_byte = b;
        w.has_byte  = has;
        w.last_byte = last;
        return w;
    endfunction

    // a message of n random bytes, some null words scattered in, last flag on the end
    task automatic queue_message(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                byte_queue.push_back(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            byte_queue.push_back(make_word(8'($urandom_range(0, 255)), 1'b1,
                                           (i == n - 1) ? 1'b1 : 1'b0));
        end
        if (n == 0)
            byte_queue.push_back(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    endtask

    task automatic wait_drained();
        while (byte_queue.size() > 0 || in_valid || digest_queue.size() > 0)
            @(posedge clk);
        // a message without its last word may still be compressing
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        double_mode = m;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int len;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        error_count  = 0;
        idle_cycles  = 0;
        hold_request = 1'b0;
        run_done     = 1'b0;
        double_mode  = 1'b0;
        restart_message();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, one byte at both extremes, stray null word,
        // byte carried on the ending word and ending word without byte,
        // 55 and 56 bytes around the second padding block, 64 for a full block
        byte_queue.push_back(make_word(8'hff, 1'b0, 1'b1));
        byte_queue.push_back(make_word(8'h00, 1'b1, 1'b1));
        byte_queue.push_back(make_word(8'hff, 1'b0, 1'b0));
        byte_queue.push_back(make_word(8'hff, 1'b1, 1'b1));
        byte_queue.push_back(make_word(8'h61, 1'b1, 1'b0));
        byte_queue.push_back(make_word(8'h62, 1'b1, 1'b0));
        byte_queue.push_back(make_word(8'h63, 1'b0, 1'b1));
        wait_drained();
        write_mode(1'b1);
        byte_queue.push_back(make_word(8'h00, 1'b0, 1'b1));
        byte_queue.push_back(make_word(8'h5a, 1'b1, 1'b1));
        wait_drained();
        write_mode(1'b0);
        queue_message(55);
        queue_message(56);
        queue_message(64);
        wait_drained();

        // random: mostly complete messages of short length, mode flipped between phases
        sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode(phase[0]);
            if (phase == 1)
                hold_request = 1'b1;
            while (sent < 62 * (phase + 1))
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 130)
                                                 : $urandom_range(0, 20);
                queue_message(len);
                sent += len + 1;
            end
            wait_drained();
            hold_request = 1'b0;
        end

        run_done = 1'b1;
        if (error_count == 0)
            $display("** sha256_stream_hasher_unit: PASSED **");
        else
            $display("** sha256_stream_hasher_unit: FAILED **");
        $finish;
    end

endmodule
